// File: hw/rtl/chained_hash_table_core_defines.svh
// ---------------------------------------------------------------------------
// chained_hash_table_core_defines
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_CORE_DEFINES_SVH

// Implication checked on every rising edge, off during reset.
`define CHT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising edge, off during reset.
`define CHT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cht_pkg.sv
// ---------------------------------------------------------------------------
// cht_pkg
// Shared constants and types of the chained hash table core.
// ---------------------------------------------------------------------------
package cht_pkg;
    localparam int BUCKETS      = 64;
    localparam int POOL_ENTRIES = 256;
    localparam int BKT_W        = $clog2(BUCKETS);
    localparam int NODE_W       = $clog2(POOL_ENTRIES);
    localparam int PTR_W        = $clog2(POOL_ENTRIES + 1);
    localparam int KEY_W        = 31;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = 9;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_ERASE  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Free-node search result handed from the allocator to the core
    typedef struct packed {
        logic              avail;
        logic [NODE_W-1:0] idx;
    } alloc_t;
endpackage

// File: hw/rtl/chained_hash_table_core.sv
// ---------------------------------------------------------------------------
// chained_hash_table_core
// Hash table with separate chaining over a fixed node pool.
// ---------------------------------------------------------------------------
// Input channel s_*: one request (insert/update, find, erase) per transfer.
// Result channel m_*: exactly one result per request, in order.
// The bucket is the low bits of the key. Bucket heads live in one memory,
// node key, data and link in separate ones; all have synchronous reads.
// Each request reads the bucket head, then walks the chain one node at a
// time in two steps (address, then compare), then writes back updates.
// One request is in flight at a time; the next transfer can be taken in
// the cycle the result appears. The result sits in an output register;
// the next request is accepted while it waits, but the walk of that
// request holds in its final state until the old result is taken.
// After reset a clearing pass writes the null pointer to every bucket head,
// during which s_ready stays low. The free-node bitmap is set to all free
// at once by reset.
// ---------------------------------------------------------------------------
module chained_hash_table_core import cht_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [KEY_W-1:0]  s_key_in,
    input  logic [DATA_W-1:0] s_data_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [DATA_W-1:0] m_data_out,
    output logic              m_status,
    output logic [CNT_W-1:0]  m_entry_count
);
    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_HEAD  = 7'b0000100,
        ST_NADDR = 7'b0001000,
        ST_NCMP  = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_WB    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Memories
    logic [PTR_W-1:0]  head_mem [BUCKETS];
    logic [KEY_W-1:0]  key_mem  [POOL_ENTRIES];
    logic [DATA_W-1:0] val_mem  [POOL_ENTRIES];
    logic [PTR_W-1:0]  link_mem [POOL_ENTRIES];
    logic [PTR_W-1:0]  head_rd;
    logic [KEY_W-1:0]  key_rd;
    logic [DATA_W-1:0] val_rd;
    logic [PTR_W-1:0]  link_rd;

    // Request and walk registers
    req_t              req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] data_reg;
    logic [PTR_W-1:0]  cur_reg, prev_reg;
    logic [PTR_W-1:0]  hit_link_reg, hit_reg;
    logic [DATA_W-1:0] hit_val_reg;
    logic              hit_found_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [NODE_W:0]   steps_reg;
    logic [BKT_W-1:0]  clr_reg;
    logic [CNT_W-1:0]  count_reg;

    // Output register
    logic              m_valid_reg;
    logic              found_reg, status_reg;
    logic [DATA_W-1:0] dout_reg;
    logic [CNT_W-1:0]  ecnt_reg;

    logic [BKT_W-1:0]  bkt;
    logic [NODE_W-1:0] cur_idx;
    logic              take, give;
    alloc_t            alloc;

    assign bkt     = key_reg[BKT_W-1:0];
    assign cur_idx = cur_reg[NODE_W-1:0];
    assign s_ready = (state_reg == ST_IDLE);

    // Free-node allocator
    logic do_wb_ins, do_wb_erase;
    assign do_wb_ins   = (state_reg == ST_WB) && (req_reg == REQ_INSERT) && !hit_found_reg
                         && alloc.avail;
    assign do_wb_erase = (state_reg == ST_WB) && (req_reg == REQ_ERASE) && hit_found_reg;
    assign take = do_wb_ins;
    assign give = do_wb_erase;

    cht_alloc u_alloc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .take_idx (alloc.idx),
        .give     (give),
        .give_idx (hit_reg[NODE_W-1:0]),
        .alloc    (alloc)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == BKT_W'(BUCKETS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = ST_HEAD;
            ST_HEAD:  state_next = ST_NADDR;
            ST_NADDR: begin
                if (cur_reg >= NIL || steps_reg == (NODE_W+1)'(POOL_ENTRIES))
                    state_next = ST_DONE;
                else
                    state_next = ST_NCMP;
            end
            ST_NCMP:  state_next = (key_rd == key_reg) ? ST_DONE : ST_NADDR;
            ST_DONE:  if (!m_valid_reg || m_ready) state_next = ST_WB;
            ST_WB:    state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Memory ports
    always_ff @(posedge aclk) begin
        // bucket head: clear, read, write back
        if (state_reg == ST_CLEAR) begin
            head_mem[clr_reg] <= NIL;
        end else if (do_wb_ins) begin
            head_mem[bkt] <= PTR_W'(alloc.idx);
        end else if (do_wb_erase && prev_reg >= NIL) begin
            head_mem[bkt] <= hit_link_reg;
        end
        head_rd <= head_mem[s_key_in[BKT_W-1:0]];

        // node memories
        if (do_wb_ins) begin
            key_mem[alloc.idx]  <= key_reg;
            val_mem[alloc.idx]  <= data_reg;
            link_mem[alloc.idx] <= head_reg;
        end
        if ((state_reg == ST_WB) && (req_reg == REQ_INSERT) && hit_found_reg)
            val_mem[hit_reg[NODE_W-1:0]] <= data_reg;
        if (do_wb_erase && prev_reg < NIL)
            link_mem[prev_reg[NODE_W-1:0]] <= hit_link_reg;
        key_rd  <= key_mem[cur_idx];
        val_rd  <= val_mem[cur_idx];
        link_rd <= link_mem[cur_idx];
    end

    // Control and count registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (state_reg == ST_WB) begin
                m_valid_reg <= 1'b1;
                if (do_wb_ins) count_reg <= count_reg + 1'b1;
                else if (do_wb_erase && count_reg != '0) count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                req_reg       <= req_t'(s_req_type);
                key_reg       <= s_key_in;
                data_reg      <= s_data_in;
                prev_reg      <= NIL;
                steps_reg     <= '0;
                hit_found_reg <= 1'b0;
                hit_reg       <= NIL;
            end
            ST_HEAD: begin
                head_reg <= head_rd;
                cur_reg  <= (req_reg == REQ_NONE) ? NIL : head_rd;
            end
            ST_NCMP: begin
                if (key_rd == key_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_reg       <= cur_reg;
                    hit_val_reg   <= val_rd;
                    hit_link_reg  <= link_rd;
                end else begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= link_rd;
                    steps_reg <= steps_reg + 1'b1;
                end
            end
            ST_WB: begin
                found_reg  <= hit_found_reg;
                dout_reg   <= (req_reg == REQ_FIND && hit_found_reg) ? hit_val_reg : '0;
                status_reg <= (req_reg == REQ_INSERT) && !hit_found_reg && !alloc.avail;
                if (do_wb_ins) ecnt_reg <= count_reg + 1'b1;
                else if (do_wb_erase && count_reg != '0) ecnt_reg <= count_reg - 1'b1;
                else ecnt_reg <= count_reg;
            end
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = found_reg;
    assign m_data_out    = dout_reg;
    assign m_status      = status_reg;
    assign m_entry_count = ecnt_reg;
endmodule

// File: hw/rtl/cht_alloc.sv
// ---------------------------------------------------------------------------
// cht_alloc
// Free-node bitmap with a registered lowest-free-index search.
// ---------------------------------------------------------------------------
module cht_alloc import cht_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [NODE_W-1:0] take_idx,
    input  logic              give,
    input  logic [NODE_W-1:0] give_idx,
    output alloc_t            alloc
);
    logic [POOL_ENTRIES-1:0] free_reg;
    alloc_t                  alloc_reg;
    alloc_t                  alloc_next;

    // Priority-encode the lowest free node
    always_comb begin
        alloc_next = '0;
        for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                alloc_next.avail = 1'b1;
                alloc_next.idx   = NODE_W'(i);
            end
        end
    end

    // Update bitmap; the search result is registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg  <= '1;
            alloc_reg <= '0;
        end else begin
            if (take) free_reg[take_idx] <= 1'b0;
            if (give) free_reg[give_idx] <= 1'b1;
            alloc_reg <= alloc_next;
        end
    end

    assign alloc = alloc_reg;
endmodule

// File: hw/rtl/cht_checker.sv
// ---------------------------------------------------------------------------
// cht_checker
// Port-level checks of the chained hash table core.
// ---------------------------------------------------------------------------
`include "chained_hash_table_core_defines.svh"

module cht_checker import cht_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_found,
    input logic [DATA_W-1:0] m_data_out,
    input logic              m_status,
    input logic [CNT_W-1:0]  m_entry_count
);
    // Hold a stalled result
    `CHT_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data_out), "stalled result changed")
    // A dropped insert never reports a hit
    `CHT_ASSERT_IMPL(a_drop, aclk, aresetn, m_valid && m_status, !m_found, "drop with hit")
    // Count never exceeds the pool
    `CHT_ASSERT_IMPL(a_cnt, aclk, aresetn, m_valid, m_entry_count <= CNT_W'(POOL_ENTRIES),
        "count over pool")
    // No new transfer in the cycle after one is taken
    `CHT_ASSERT_NEXT(a_seq, aclk, aresetn, s_valid && s_ready, !s_ready, "back to back accept")
endmodule

bind chained_hash_table_core cht_checker u_cht_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_found       (m_found),
    .m_data_out    (m_data_out),
    .m_status      (m_status),
    .m_entry_count (m_entry_count)
);
